FILE: hdl/affinity_ready_queue_unit_assert.svh
// assertion macros for the ready queue unit
// expect clk_i and rst_ni in the scope of the use
`ifndef AFFINITY_READY_QUEUE_UNIT_ASSERT_SVH
`define AFFINITY_READY_QUEUE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ARQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ARQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/arq_pkg.sv
package arq_pkg;

  // default queue depth and number of cores served
  localparam int unsigned DEF_MAX_PROCS = 32;
  localparam int unsigned NUM_CORES     = 4;

  localparam int unsigned PID_W  = 5;
  localparam int unsigned MASK_W = 4;
  localparam int unsigned CORE_W = 2;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    OUT_INSERTED  = 3'd0,
    OUT_DUPLICATE = 3'd1,
    OUT_SKIPPED   = 3'd2,
    OUT_GRANTED   = 3'd3,
    OUT_NONE      = 3'd4,
    OUT_FULL      = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [PID_W-1:0]  proc_id;
    logic [MASK_W-1:0] affinity_mask;
    logic              running_elsewhere;
    logic [CORE_W-1:0] core_id;
  } in_item_t;

  typedef struct packed {
    outcome_e         outcome;
    logic [PID_W-1:0] granted_id;
  } out_item_t;

  // one queue entry
  typedef struct packed {
    logic [PID_W-1:0]  id;
    logic [MASK_W-1:0] mask;
  } slot_t;

  // what the compare unit looks for
  typedef struct packed {
    op_e               op;
    logic [PID_W-1:0]  proc_id;
    logic [CORE_W-1:0] core_id;
  } match_key_t;

endpackage

FILE: hdl/arq_slot_ram.sv
module arq_slot_ram import arq_pkg::*; #(
  parameter int unsigned Depth = DEF_MAX_PROCS,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  slot_t            wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output slot_t            rd_data_o
);

  slot_t mem_q [Depth];
  slot_t rd_data_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/arq_match_unit.sv
module arq_match_unit import arq_pkg::*; (
  input  slot_t      entry_i,
  input  match_key_t key_i,
  output logic       hit_o
);

  // insert looks for the same id, dequeue for the core's affinity bit
  always_comb begin
    case (key_i.op)
      OP_INSERT:  hit_o = (entry_i.id == key_i.proc_id);
      OP_DEQUEUE: hit_o = entry_i.mask[key_i.core_id];
      default:    hit_o = 1'b0;
    endcase
  end

endmodule

FILE: hdl/affinity_ready_queue_unit.sv
// flow: an accepted transaction scans the queued entries in ST_SCAN, then its result is
//   loaded from ST_RESULT; a skipped insert or an unknown core goes straight to
//   ST_RESULT, and a scan stops early when a duplicate id is found
// throughput: one transaction at a time, the next is taken once the result
//   is loaded; the result waits in ST_RESULT while the output is stalled
// reset: queue empty, no result pending; slot contents are not cleared
`include "affinity_ready_queue_unit_assert.svh"

module affinity_ready_queue_unit import arq_pkg::*; #(
  parameter int unsigned MAX_PROCS = DEF_MAX_PROCS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);

  state_e           state_q, state_d;
  in_item_t         item_q, item_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]  chk_q, chk_d;
  logic             rvalid_q, rvalid_d;
  logic             found_q, found_d;
  logic [PID_W-1:0] gid_q, gid_d;
  outcome_e         res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic             rd_en, wr_en;
  logic [IdxW-1:0]  wr_addr;
  slot_t            wr_data, rd_data;
  match_key_t       key;
  logic             hit;

  // slot storage
  arq_slot_ram #(
    .Depth(MAX_PROCS)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_idx_q[IdxW-1:0]),
    .rd_data_o(rd_data)
  );

  // shared compare unit, fed one slot per cycle
  assign key = '{op: item_q.op, proc_id: item_q.proc_id, core_id: item_q.core_id};

  arq_match_unit u_match_unit (
    .entry_i(rd_data),
    .key_i  (key),
    .hit_o  (hit)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      rd_idx_q    <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rd_idx_q    <= rd_idx_d;
      rvalid_q    <= rvalid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    chk_q      <= chk_d;
    gid_q      <= gid_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    chk_d       = rd_idx_q[IdxW-1:0];
    rvalid_d    = 1'b0;
    found_d     = found_q;
    gid_d       = gid_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = len_q[IdxW-1:0];
    wr_data     = '{id: item_q.proc_id, mask: item_q.affinity_mask};
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d   = in_item_i;
          rd_idx_d = '0;
          found_d  = 1'b0;
          gid_d    = '0;
          if (in_item_i.op == OP_INSERT && in_item_i.running_elsewhere) begin
            res_d   = OUT_SKIPPED;
            state_d = ST_RESULT;
          end else if (in_item_i.op == OP_DEQUEUE &&
                       32'(in_item_i.core_id) >= NUM_CORES) begin
            res_d   = OUT_NONE;
            state_d = ST_RESULT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rvalid_q && item_q.op == OP_INSERT && hit) begin
          // id already queued, stop the scan
          res_d   = OUT_DUPLICATE;
          state_d = ST_RESULT;
        end else if (!rvalid_q && rd_idx_q == len_q) begin
          // scan drained: commit the transaction
          state_d = ST_RESULT;
          if (item_q.op == OP_INSERT) begin
            if (len_q == CntW'(MAX_PROCS)) begin
              res_d = OUT_FULL;
            end else begin
              wr_en = 1'b1;
              len_d = len_q + 1'b1;
              res_d = OUT_INSERTED;
            end
          end else if (found_q) begin
            len_d = len_q - 1'b1;
            res_d = OUT_GRANTED;
          end else begin
            res_d = OUT_NONE;
          end
        end else begin
          // issue the next slot read
          if (rd_idx_q != len_q) begin
            rd_en    = 1'b1;
            rvalid_d = 1'b1;
            rd_idx_d = rd_idx_q + 1'b1;
          end
          // dequeue: find the first eligible slot, then move later ones up
          if (rvalid_q && item_q.op == OP_DEQUEUE) begin
            if (found_q) begin
              wr_en   = 1'b1;
              wr_addr = chk_q - 1'b1;
              wr_data = rd_data;
            end else if (hit) begin
              found_d = 1'b1;
              gid_d   = rd_data.id;
            end
          end
        end
      end

      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_item_d.outcome    = res_q;
          out_item_d.granted_id = gid_q;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  `ARQ_ASSERT_IMP(a_len_bound, 1'b1, len_q <= CntW'(MAX_PROCS), "queue length over depth")
  `ARQ_ASSERT_IMP(a_rd_in_queue, rd_en, rd_idx_q < len_q, "slot read beyond queue length")
  `ARQ_ASSERT_IMP(a_no_port_clash, wr_en && rd_en, wr_addr != rd_idx_q[IdxW-1:0], "read and write hit one slot")
  `ARQ_ASSERT_IMP(a_idle_drained, state_q == ST_IDLE, !rvalid_q, "slot read pending while idle")
  `ARQ_ASSERT_IMP(a_id_zero, out_valid_o && out_item_o.outcome != OUT_GRANTED, out_item_o.granted_id == '0, "id set on non-granted result")
  `ARQ_ASSERT_NXT(a_grant_shrinks, state_q == ST_SCAN && state_d == ST_RESULT && res_d == OUT_GRANTED, len_q == $past(len_q) - 1'b1, "grant without removal")

endmodule
